FILE: rtl/plunger_homing_sequencer_assert.svh
// Assertion macros for the plunger homing sequencer.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef PLUNGER_HOMING_SEQUENCER_ASSERT_SVH
`define PLUNGER_HOMING_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define PHS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/phs_pkg.sv
// Shared types, codes and reset constants for the plunger homing sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package phs_pkg;

  localparam int CNT_W = 32;   // width of step counts and top position

  // one-hot sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE        = 5'b00001,
    PH_WAIT_ON     = 5'b00010,
    PH_WAIT_OFF    = 5'b00100,
    PH_MILEAGE     = 5'b01000,
    PH_END_MILEAGE = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_BUSY    = 3'd1,
    ST_DONE    = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_BREAK   = 3'd4,
    ST_ENDPOS  = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    MODE_DOWN       = 4'd0,
    MODE_UP         = 4'd1,
    MODE_STOP       = 4'd2,
    MODE_TICK       = 4'd3,
    MODE_SENSOR_ON  = 4'd4,
    MODE_SENSOR_OFF = 4'd5,
    MODE_MOTOR_OFF  = 4'd6,
    MODE_KEY        = 4'd7,
    MODE_FORGET     = 4'd8
  } mode_t;

  localparam logic [1:0] ARG_DOWN_SENSOR = 2'd0;
  localparam logic [1:0] ARG_UP_SENSOR   = 2'd1;
  localparam logic [1:0] ARG_STOP_KEY    = 2'd1;

  // register map index (byte address / 4)
  localparam logic [1:0] REG_TIMEOUT    = 2'd0;
  localparam logic [1:0] REG_CRAWL_RATE = 2'd1;
  localparam logic [1:0] REG_SLOW_POS   = 2'd2;
  localparam logic [1:0] REG_MILEAGE    = 2'd3;

  localparam logic [31:0] TIMEOUT_RST    = 32'd30000;
  localparam logic [7:0]  CRAWL_RATE_RST = 8'd10;
  localparam logic [31:0] SLOW_POS_RST   = 32'd1000;
  localparam logic [15:0] MILEAGE_RST    = 16'd2000;

  typedef struct packed {
    logic [31:0] timeout_ticks;
    logic [7:0]  crawl_rate;
    logic [31:0] slow_zone_pos;
    logic [15:0] backoff_steps;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [1:0]  event_arg;
    logic        down_sensor_now;
    logic        up_sensor_now;
    logic [31:0] step_count;
    logic [7:0]  motor_rate_now;
    logic [31:0] now_ticks;
  } item_t;

  typedef struct packed {
    logic        do_start;
    logic        start_direction;
    logic [7:0]  start_rate;
    logic        do_decelerate;
    logic        do_change_rate;
    logic [31:0] position;
    logic [2:0]  status;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/plunger_homing_sequencer.sv
// Plunger homing sequencer, top level.
// Event words come in on the in_ channel (valid/ready) and are registered.
// Each word is decoded combinationally against the sequencer state and its
// single result word lands in the out_ register, handed off on out_ready.
// Path: a word passes the input register, then the result register, where
// out_valid rises; the result word is taken while out_ready is high.
// Throughput: one word per cycle while out_ready stays high; the state updates once per word.
// A stalled receiver holds the result register; one more word waits in the
// input register, and in_ready drops only when both are full.
// Four registers sit on the APB-style port at byte addresses 0, 4, 8, 12:
// timeout_ticks, crawl_rate, slow_zone_pos, backoff_steps.
// Write them only while no word is in flight.
// Reset (rst_n low, synchronous) empties both registers, puts the sequencer
// in idle with an unknown position and restores the register defaults.
// Depends on phs_pkg, phs_cfg_regs, phs_core and the assertion macro header.
`default_nettype none

module plunger_homing_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_mode,
  input  wire logic [1:0]  in_event_arg,
  input  wire logic        in_down_sensor_now,
  input  wire logic        in_up_sensor_now,
  input  wire logic [31:0] in_step_count,
  input  wire logic [7:0]  in_motor_rate_now,
  input  wire logic [31:0] in_now_ticks,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_do_start,
  output logic             out_start_direction,
  output logic [7:0]       out_start_rate,
  output logic             out_do_decelerate,
  output logic             out_do_change_rate,
  output logic [31:0]      out_position,
  output logic [2:0]       out_status,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import phs_pkg::*;

`include "plunger_homing_sequencer_assert.svh"

  cfg_t    cfg;
  item_t   s1_item_r;
  logic    s1_valid_r;
  logic    s1_adv;
  logic    out_free;
  logic    in_fire;
  result_t result;

  phs_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign s1_adv   = s1_valid_r & out_free;
  assign in_ready = ~s1_valid_r | out_free;
  assign in_fire  = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.mode            <= in_mode;
      s1_item_r.event_arg       <= in_event_arg;
      s1_item_r.down_sensor_now <= in_down_sensor_now;
      s1_item_r.up_sensor_now   <= in_up_sensor_now;
      s1_item_r.step_count      <= in_step_count;
      s1_item_r.motor_rate_now  <= in_motor_rate_now;
      s1_item_r.now_ticks       <= in_now_ticks;
    end
  end

  phs_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (s1_adv),
    .item       (s1_item_r),
    .out_ready  (out_ready),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .result     (result)
  );

  assign out_do_start        = result.do_start;
  assign out_start_direction = result.start_direction;
  assign out_start_rate      = result.start_rate;
  assign out_do_decelerate   = result.do_decelerate;
  assign out_do_change_rate  = result.do_change_rate;
  assign out_position        = result.position;
  assign out_status          = result.status;

  // start and decelerate come from disjoint events
  `PHS_ASSERT_NOW(a_start_decel_excl, out_valid, !(out_do_start && out_do_decelerate), "start and decelerate together")
  // direction and rate are zero unless a start is commanded
  `PHS_ASSERT_NOW(a_start_fields, out_valid && !out_do_start, out_start_rate == 8'd0 && !out_start_direction, "start fields without start")
  // a word held in the input register is never dropped while output stalls
  `PHS_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r, "input word lost")

endmodule

`default_nettype wire

FILE: rtl/phs_cfg_regs.sv
// APB-style configuration registers of the plunger homing sequencer.
// Depends on phs_pkg for the register map and reset values.
`default_nettype none

module phs_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output phs_pkg::cfg_t      cfg
);
  import phs_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_TIMEOUT:    cfg_nxt.timeout_ticks = pwdata;
        REG_CRAWL_RATE: cfg_nxt.crawl_rate    = pwdata[7:0];
        REG_SLOW_POS:   cfg_nxt.slow_zone_pos = pwdata;
        REG_MILEAGE:    cfg_nxt.backoff_steps = pwdata[15:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ticks <= TIMEOUT_RST;
      cfg_r.crawl_rate    <= CRAWL_RATE_RST;
      cfg_r.slow_zone_pos <= SLOW_POS_RST;
      cfg_r.backoff_steps <= MILEAGE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_TIMEOUT:    prdata = cfg_r.timeout_ticks;
      REG_CRAWL_RATE: prdata = {24'd0, cfg_r.crawl_rate};
      REG_SLOW_POS:   prdata = cfg_r.slow_zone_pos;
      REG_MILEAGE:    prdata = {16'd0, cfg_r.backoff_steps};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: rtl/phs_core.sv
// Sequencer state, per-word event decode and the result register.
// Depends on phs_pkg; fed by the input stage of the top level.
`default_nettype none

module phs_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire phs_pkg::cfg_t cfg,
  input  wire logic          item_valid,
  input  wire phs_pkg::item_t item,
  input  wire logic          out_ready,
  output logic               out_free,
  output logic               out_valid,
  output phs_pkg::result_t   result
);
  import phs_pkg::*;

  phase_t           phase_r, phase_nxt, ph_tick;
  logic             up_r, up_nxt;
  logic [CNT_W-1:0] top_r, top_nxt;
  logic             unk_r, unk_nxt;
  status_t          code_r, code_nxt;
  logic [31:0]      tick_r, tick_nxt;

  logic             out_valid_r;
  result_t          res_r, res_nxt;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] pos_cur;
  logic [CNT_W-1:0] pos_new;
  logic [31:0]      elapsed;
  logic             at_end;
  logic             force_none;
  logic             timed_out;

  function automatic logic [CNT_W-1:0] calc_pos(input logic up,
                                                input logic [CNT_W-1:0] top,
                                                input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] p;
    if (up)             p = cnt;
    else if (cnt > top) p = '0;
    else                p = top - cnt;
    return p;
  endfunction

  assign count     = item.step_count[CNT_W-1:0];
  assign pos_cur   = calc_pos(up_r, top_r, count);
  assign elapsed   = item.now_ticks - tick_r;
  assign timed_out = (phase_r != PH_IDLE) && (elapsed >= cfg.timeout_ticks);

  always_comb begin
    phase_nxt  = phase_r;
    up_nxt     = up_r;
    top_nxt    = top_r;
    unk_nxt    = unk_r;
    code_nxt   = code_r;
    tick_nxt   = tick_r;
    res_nxt    = '0;
    force_none = 1'b0;
    at_end     = 1'b0;
    ph_tick    = phase_r;

    case (item.mode)
      MODE_DOWN, MODE_UP: begin
        up_nxt   = (item.mode == MODE_UP);
        at_end   = up_nxt ? item.up_sensor_now : item.down_sensor_now;
        phase_nxt = PH_IDLE;
        code_nxt  = ST_DONE;
        if (!at_end) begin
          phase_nxt               = PH_WAIT_ON;
          res_nxt.do_start        = 1'b1;
          res_nxt.start_direction = up_nxt;
          tick_nxt                = item.now_ticks;
        end else if (unk_r) begin
          // resting on the sensor with unknown position: back off first
          phase_nxt               = PH_MILEAGE;
          res_nxt.do_start        = 1'b1;
          res_nxt.start_direction = ~up_nxt;
          tick_nxt                = item.now_ticks;
        end
      end
      MODE_STOP: begin
        if (phase_r != PH_IDLE) begin
          phase_nxt             = PH_WAIT_OFF;
          res_nxt.do_decelerate = 1'b1;
          code_nxt              = ST_DONE;
        end
        force_none = 1'b1;
      end
      MODE_TICK: begin
        if (timed_out) begin
          ph_tick               = PH_WAIT_OFF;
          res_nxt.do_decelerate = 1'b1;
          code_nxt              = ST_TIMEOUT;
        end else if (phase_r == PH_MILEAGE &&
                     count >= CNT_W'(cfg.backoff_steps)) begin
          ph_tick               = PH_END_MILEAGE;
          res_nxt.do_decelerate = 1'b1;
        end
        phase_nxt = ph_tick;
        if (!up_r && top_r != '0 && item.motor_rate_now > cfg.crawl_rate &&
            32'(pos_cur) <= cfg.slow_zone_pos)
          res_nxt.do_change_rate = 1'b1;
      end
      MODE_SENSOR_ON: begin
        if (phase_r == PH_WAIT_ON &&
            ((item.event_arg == ARG_DOWN_SENSOR && !up_r) ||
             (item.event_arg == ARG_UP_SENSOR && up_r))) begin
          phase_nxt             = PH_WAIT_OFF;
          res_nxt.do_decelerate = 1'b1;
        end
      end
      MODE_MOTOR_OFF: begin
        if (phase_r == PH_END_MILEAGE) begin
          // back-off finished: re-approach at slow rate
          top_nxt                 = '0;
          phase_nxt               = PH_WAIT_ON;
          res_nxt.do_start        = 1'b1;
          res_nxt.start_direction = up_r;
          res_nxt.start_rate      = cfg.crawl_rate;
        end else begin
          top_nxt   = (up_r && !item.up_sensor_now) ? count : '0;
          phase_nxt = PH_IDLE;
          unk_nxt   = 1'b0;
        end
      end
      MODE_KEY: begin
        if (item.event_arg == ARG_STOP_KEY) begin
          phase_nxt             = PH_WAIT_OFF;
          res_nxt.do_decelerate = 1'b1;
          code_nxt              = ST_BREAK;
        end
      end
      MODE_FORGET: unk_nxt = 1'b1;
      default: ;
    endcase

    pos_new          = calc_pos(up_nxt, top_nxt, count);
    res_nxt.position = 32'(pos_new);
    if (force_none)                res_nxt.status = ST_NONE;
    else if (phase_nxt != PH_IDLE) res_nxt.status = ST_BUSY;
    else if (item.up_sensor_now)   res_nxt.status = ST_ENDPOS;
    else                           res_nxt.status = code_nxt;
  end

  assign out_free = ~out_valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      up_r        <= 1'b0;
      top_r       <= '0;
      unk_r       <= 1'b1;
      code_r      <= ST_NONE;
      tick_r      <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_valid) begin
        phase_r <= phase_nxt;
        up_r    <= up_nxt;
        top_r   <= top_nxt;
        unk_r   <= unk_nxt;
        code_r  <= code_nxt;
        tick_r  <= tick_nxt;
      end
      if (out_free) out_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid) res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

endmodule

`default_nettype wire
